### src/rbg_pkg.sv
`default_nettype none
package rbg_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int DT_BITS      = 17;
    localparam int MAG_BITS     = 31;
    localparam int CFG_IDX_BITS = 3;
    localparam int ROOT_BITS    = WORD_BITS;
    localparam int RAD_BITS     = 2 * WORD_BITS;
    localparam int PROD_BITS    = WORD_BITS + DT_BITS;
    localparam int QRES_BITS    = PROD_BITS - FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        uword_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELTA_TIME      = 3'd0,
        CFG_GROUND_Y        = 3'd1,
        CFG_GRAVITY_ACCEL   = 3'd2,
        CFG_TERMINAL_SPEED  = 3'd3,
        CFG_GROUND_FRICTION = 3'd4
    } cfg_idx_t;

    localparam logic [DT_BITS-1:0]  RST_DELTA_TIME      = 17'd1092;
    localparam word_t               RST_GROUND_Y        = '0;
    localparam logic [MAG_BITS-1:0] RST_GRAVITY_ACCEL   = 31'd642908;
    localparam logic [MAG_BITS-1:0] RST_TERMINAL_SPEED  = 31'd3276800;
    localparam logic [MAG_BITS-1:0] RST_GROUND_FRICTION = 31'd327680;

    typedef struct packed {
        word_t                px;
        word_t                py;
        word_t                pz;
        word_t                vx;
        word_t                vy;
        word_t                vz;
        logic                 use_gravity;
        logic                 has_collider;
        logic [MAG_BITS-1:0]  half_extent;
    } body_in_t;

    typedef struct packed {
        word_t px;
        word_t py;
        word_t pz;
        word_t vx;
        word_t vy;
        word_t vz;
        logic  grounded;
    } body_t;

    function automatic word_t sat_wide(input logic signed [WORD_BITS:0] s);
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        return sat_wide(s);
    endfunction

    function automatic uword_t mag(input word_t a);
        uword_t u;
        u = a;
        return u[WORD_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    // (|a| * b) >> FRAC_BITS toward zero, sign restored, saturated
    function automatic word_t mulq(input word_t a, input logic [DT_BITS-1:0] b);
        logic [PROD_BITS-1:0] p;
        logic [QRES_BITS-1:0] r;
        p = {{DT_BITS{1'b0}}, mag(a)} * {{WORD_BITS{1'b0}}, b};
        r = p[PROD_BITS-1:FRAC_BITS];
        if (a[WORD_BITS-1]) begin
            if (r[QRES_BITS-1] || (r[WORD_BITS-1] && (|r[WORD_BITS-2:0]))) begin
                return WORD_MIN;
            end
            return word_t'(~r[WORD_BITS-1:0] + 1'b1);
        end
        if (r[QRES_BITS-1] || r[WORD_BITS-1]) begin
            return WORD_MAX;
        end
        return word_t'(r[WORD_BITS-1:0]);
    endfunction

endpackage
`default_nettype wire

### src/rbg_front.sv
`default_nettype none
module rbg_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire rbg_pkg::body_in_t              in_body,
    input  wire logic [rbg_pkg::DT_BITS-1:0]    dt,
    input  wire rbg_pkg::word_t                 gdt,
    input  wire rbg_pkg::word_t                 ground_y,
    input  wire rbg_pkg::word_t                 term,
    output logic                                out_valid,
    output rbg_pkg::body_t                      out_body,
    output logic [rbg_pkg::RAD_BITS-1:0]        out_rad
);

    typedef struct packed {
        rbg_pkg::word_t                 px;
        rbg_pkg::word_t                 py;
        rbg_pkg::word_t                 pz;
        rbg_pkg::word_t                 vx;
        rbg_pkg::word_t                 vy;
        rbg_pkg::word_t                 vz;
        rbg_pkg::word_t                 pdx;
        rbg_pkg::word_t                 pdz;
        rbg_pkg::word_t                 rest;
        logic [rbg_pkg::RAD_BITS-1:0]   ax2;
        logic [rbg_pkg::RAD_BITS-1:0]   az2;
        logic                           has_col;
    } st1_t;

    typedef struct packed {
        rbg_pkg::word_t                 px;
        rbg_pkg::word_t                 py;
        rbg_pkg::word_t                 pz;
        rbg_pkg::word_t                 vx;
        rbg_pkg::word_t                 vy;
        rbg_pkg::word_t                 vz;
        rbg_pkg::word_t                 pdy;
        rbg_pkg::word_t                 rest;
        logic [rbg_pkg::RAD_BITS-1:0]   sq;
        logic                           has_col;
    } st2_t;

    logic                          v1_reg, v2_reg, v3_reg;
    st1_t                          s1_reg, s1_next;
    st2_t                          s2_reg, s2_next;
    rbg_pkg::body_t                s3_reg, s3_next;
    logic [rbg_pkg::RAD_BITS-1:0]  rad_reg, rad_next;

    rbg_pkg::word_t                vy_g;
    rbg_pkg::uword_t               ax, az;
    rbg_pkg::word_t                py_n;
    logic                          hit;

    // gravity, terminal clamp, horizontal moves, rest height, squares
    always_comb begin
        vy_g = in_body.use_gravity ? rbg_pkg::sat_add(in_body.vy, -gdt) : in_body.vy;
        ax   = rbg_pkg::mag(in_body.vx);
        az   = rbg_pkg::mag(in_body.vz);
        s1_next.px      = in_body.px;
        s1_next.py      = in_body.py;
        s1_next.pz      = in_body.pz;
        s1_next.vx      = in_body.vx;
        s1_next.vz      = in_body.vz;
        s1_next.vy      = (vy_g < term) ? term : vy_g;
        s1_next.pdx     = rbg_pkg::mulq(in_body.vx, dt);
        s1_next.pdz     = rbg_pkg::mulq(in_body.vz, dt);
        s1_next.rest    = rbg_pkg::sat_add(ground_y,
                              rbg_pkg::word_t'({1'b0, in_body.half_extent}));
        s1_next.ax2     = {{rbg_pkg::WORD_BITS{1'b0}}, ax} * {{rbg_pkg::WORD_BITS{1'b0}}, ax};
        s1_next.az2     = {{rbg_pkg::WORD_BITS{1'b0}}, az} * {{rbg_pkg::WORD_BITS{1'b0}}, az};
        s1_next.has_col = in_body.has_collider;
    end

    always_comb begin
        s2_next.px      = rbg_pkg::sat_add(s1_reg.px, s1_reg.pdx);
        s2_next.pz      = rbg_pkg::sat_add(s1_reg.pz, s1_reg.pdz);
        s2_next.py      = s1_reg.py;
        s2_next.vx      = s1_reg.vx;
        s2_next.vy      = s1_reg.vy;
        s2_next.vz      = s1_reg.vz;
        s2_next.pdy     = rbg_pkg::mulq(s1_reg.vy, dt);
        s2_next.rest    = s1_reg.rest;
        s2_next.sq      = s1_reg.ax2 + s1_reg.az2;
        s2_next.has_col = s1_reg.has_col;
    end

    // ground test: a grounded body snaps to rest height and stops vertically
    always_comb begin
        py_n = rbg_pkg::sat_add(s2_reg.py, s2_reg.pdy);
        hit  = s2_reg.has_col && (py_n <= s2_reg.rest);
        s3_next.px       = s2_reg.px;
        s3_next.pz       = s2_reg.pz;
        s3_next.vx       = s2_reg.vx;
        s3_next.vz       = s2_reg.vz;
        s3_next.py       = hit ? s2_reg.rest : py_n;
        s3_next.vy       = hit ? '0 : s2_reg.vy;
        s3_next.grounded = hit;
        rad_next         = hit ? s2_reg.sq : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            rad_reg <= rad_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_body  = s3_reg;
    assign out_rad   = rad_reg;

endmodule
`default_nettype wire

### src/rbg_sqrt.sv
`default_nettype none
module rbg_sqrt (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire rbg_pkg::body_t                 in_body,
    input  wire logic [rbg_pkg::RAD_BITS-1:0]   in_rad,
    output logic                                out_valid,
    output rbg_pkg::body_t                      out_body,
    output rbg_pkg::uword_t                     out_root
);

    localparam int STEPS   = rbg_pkg::ROOT_BITS;
    localparam int REM_W   = rbg_pkg::ROOT_BITS + 2;
    localparam int SH_W    = REM_W + 2;

    typedef struct packed {
        rbg_pkg::body_t                 body;
        logic [rbg_pkg::RAD_BITS-1:0]   rad;
        logic [REM_W-1:0]               rem;
        rbg_pkg::uword_t                root;
    } sq_st_t;

    logic    vld_in  [STEPS];
    logic    vld_reg [STEPS];
    sq_st_t  st_in   [STEPS];
    sq_st_t  st_next [STEPS];
    sq_st_t  st_reg  [STEPS];

    assign vld_in[0]     = in_valid;
    assign st_in[0].body = in_body;
    assign st_in[0].rad  = in_rad;
    assign st_in[0].rem  = '0;
    assign st_in[0].root = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [SH_W-1:0] rem_sh, trial;

        if (k > 0) begin : g_link
            assign vld_in[k] = vld_reg[k-1];
            assign st_in[k]  = st_reg[k-1];
        end

        // one root bit per stage: bring down two radicand bits, try subtract
        always_comb begin
            rem_sh = {st_in[k].rem, st_in[k].rad[rbg_pkg::RAD_BITS-1 -: 2]};
            trial  = {2'b00, st_in[k].root, 2'b01};
            st_next[k].body = st_in[k].body;
            st_next[k].rad  = {st_in[k].rad[rbg_pkg::RAD_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                st_next[k].rem  = REM_W'(rem_sh - trial);
                st_next[k].root = {st_in[k].root[rbg_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                st_next[k].rem  = REM_W'(rem_sh);
                st_next[k].root = {st_in[k].root[rbg_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_body  = st_reg[STEPS-1].body;
    assign out_root  = st_reg[STEPS-1].root;

endmodule
`default_nettype wire

### src/rbg_scale.sv
`default_nettype none
module rbg_scale (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire rbg_pkg::body_t     in_body,
    input  wire rbg_pkg::uword_t    in_speed,
    input  wire rbg_pkg::word_t     dec,
    output logic                    out_valid,
    output rbg_pkg::body_t          out_body
);

    localparam int W     = rbg_pkg::WORD_BITS;
    localparam int STEPS = rbg_pkg::WORD_BITS;

    typedef struct packed {
        rbg_pkg::body_t  body;
        rbg_pkg::uword_t speed;
        rbg_pkg::uword_t ns;
    } pre_st_t;

    typedef struct packed {
        rbg_pkg::body_t       body;
        rbg_pkg::uword_t      den;
        logic                 byp;
        logic [1:0][W-1:0]    rem;
        logic [1:0][W-1:0]    lo;
        logic [1:0][W-1:0]    q;
    } dv_st_t;

    logic            p1_vld_reg, p2_vld_reg, out_vld_reg;
    pre_st_t         p1_reg, p1_next;
    dv_st_t          p2_reg, p2_next;
    rbg_pkg::body_t  out_reg, out_next;

    logic    vld_in  [STEPS];
    logic    vld_reg [STEPS];
    dv_st_t  st_in   [STEPS];
    dv_st_t  st_next [STEPS];
    dv_st_t  st_reg  [STEPS];

    logic [2*W-1:0] nx, nz;

    // new speed after friction, never below zero
    always_comb begin
        p1_next.body  = in_body;
        p1_next.speed = in_speed;
        p1_next.ns    = (in_speed > rbg_pkg::uword_t'(dec)) ?
                        (in_speed - rbg_pkg::uword_t'(dec)) : '0;
    end

    // numerators |v| * new_speed, divided by speed below
    always_comb begin
        nx = {{W{1'b0}}, rbg_pkg::mag(p1_reg.body.vx)} * {{W{1'b0}}, p1_reg.ns};
        nz = {{W{1'b0}}, rbg_pkg::mag(p1_reg.body.vz)} * {{W{1'b0}}, p1_reg.ns};
        p2_next.body   = p1_reg.body;
        p2_next.den    = p1_reg.speed;
        p2_next.byp    = (p1_reg.speed == '0);
        p2_next.rem[0] = nx[2*W-1:W];
        p2_next.lo[0]  = nx[W-1:0];
        p2_next.rem[1] = nz[2*W-1:W];
        p2_next.lo[1]  = nz[W-1:0];
        p2_next.q      = '0;
    end

    assign vld_in[0] = p2_vld_reg;
    assign st_in[0]  = p2_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [W:0] sh [2];

        if (k > 0) begin : g_link
            assign vld_in[k] = vld_reg[k-1];
            assign st_in[k]  = st_reg[k-1];
        end

        // one quotient bit per stage for both lanes
        always_comb begin
            st_next[k].body = st_in[k].body;
            st_next[k].den  = st_in[k].den;
            st_next[k].byp  = st_in[k].byp;
            for (int l = 0; l < 2; l++) begin
                sh[l] = {st_in[k].rem[l], st_in[k].lo[l][W-1]};
                st_next[k].lo[l] = {st_in[k].lo[l][W-2:0], 1'b0};
                if (sh[l] >= {1'b0, st_in[k].den}) begin
                    st_next[k].rem[l] = W'(sh[l] - {1'b0, st_in[k].den});
                    st_next[k].q[l]   = {st_in[k].q[l][W-2:0], 1'b1};
                end else begin
                    st_next[k].rem[l] = sh[l][W-1:0];
                    st_next[k].q[l]   = {st_in[k].q[l][W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    function automatic rbg_pkg::word_t apply_sign(input rbg_pkg::word_t v,
                                                  input rbg_pkg::uword_t q);
        if (v[W-1]) begin
            return rbg_pkg::word_t'(~q + 1'b1);
        end
        return q[W-1] ? rbg_pkg::WORD_MAX : rbg_pkg::word_t'(q);
    endfunction

    always_comb begin
        out_next = st_reg[STEPS-1].body;
        if (!st_reg[STEPS-1].byp) begin
            out_next.vx = apply_sign(st_reg[STEPS-1].body.vx, st_reg[STEPS-1].q[0]);
            out_next.vz = apply_sign(st_reg[STEPS-1].body.vz, st_reg[STEPS-1].q[1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg  <= in_valid;
            p2_vld_reg  <= p1_vld_reg;
            out_vld_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_body  = out_reg;

endmodule
`default_nettype wire

### src/rigid_body_ground_step_top.sv
// Pipeline: an accepted s_ beat reaches its m_ beat through 3 kinematics stages,
//   32 square-root stages, 2 friction stages, 32 divider stages and 1 output register.
// Throughput: one body per cycle; the whole pipeline advances whenever the output
//   register is empty or its beat is taken, so a stall holds every stage in place.
// Reset: aresetn is synchronous, active low; it clears all stage valid bits and
//   loads the configuration registers with their defaults. Config writes reach the derived
//   gravity and friction step terms in the cycle after the configuration register is written.
`default_nettype none
module rigid_body_ground_step_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // config write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rbg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [rbg_pkg::WORD_BITS-1:0]      cfg_data,
    // body in
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] vel_x,
    // [159:128] vel_y, [191:160] vel_z, [222:192] half_extent, [223] zero
    input  wire logic [223:0]                       s_tdata,
    // [0] use_gravity, [1] has_collider
    input  wire logic [1:0]                         s_tuser,
    // body out
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] new_pos_x, [63:32] new_pos_y, [95:64] new_pos_z, [127:96] new_vel_x,
    // [159:128] new_vel_y, [191:160] new_vel_z
    output logic [191:0]                            m_tdata,
    // [0] grounded
    output logic [0:0]                              m_tuser
);

    localparam int W = rbg_pkg::WORD_BITS;

    // configuration registers
    logic [rbg_pkg::DT_BITS-1:0]  dt_reg;
    rbg_pkg::word_t               gy_reg;
    logic [rbg_pkg::MAG_BITS-1:0] grav_reg;
    logic [rbg_pkg::MAG_BITS-1:0] term_reg;
    logic [rbg_pkg::MAG_BITS-1:0] fric_reg;
    // derived per-step terms: gravity * dt and friction * dt
    rbg_pkg::word_t               gdt_reg;
    rbg_pkg::word_t               dec_reg;
    rbg_pkg::word_t               term_neg;

    logic              en;
    rbg_pkg::body_in_t in_body;

    logic              fr_valid;
    rbg_pkg::body_t    fr_body;
    logic [rbg_pkg::RAD_BITS-1:0] fr_rad;

    logic              sq_valid;
    rbg_pkg::body_t    sq_body;
    rbg_pkg::uword_t   sq_root;

    logic              out_valid;
    rbg_pkg::body_t    out_body;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg   <= rbg_pkg::RST_DELTA_TIME;
            gy_reg   <= rbg_pkg::RST_GROUND_Y;
            grav_reg <= rbg_pkg::RST_GRAVITY_ACCEL;
            term_reg <= rbg_pkg::RST_TERMINAL_SPEED;
            fric_reg <= rbg_pkg::RST_GROUND_FRICTION;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rbg_pkg::CFG_DELTA_TIME:      dt_reg   <= cfg_data[rbg_pkg::DT_BITS-1:0];
                rbg_pkg::CFG_GROUND_Y:        gy_reg   <= rbg_pkg::word_t'(cfg_data);
                rbg_pkg::CFG_GRAVITY_ACCEL:   grav_reg <= cfg_data[rbg_pkg::MAG_BITS-1:0];
                rbg_pkg::CFG_TERMINAL_SPEED:  term_reg <= cfg_data[rbg_pkg::MAG_BITS-1:0];
                rbg_pkg::CFG_GROUND_FRICTION: fric_reg <= cfg_data[rbg_pkg::MAG_BITS-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // recompute step terms every cycle; reset loads them from the defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gdt_reg <= rbg_pkg::mulq(rbg_pkg::word_t'({1'b0, rbg_pkg::RST_GRAVITY_ACCEL}),
                                     rbg_pkg::RST_DELTA_TIME);
            dec_reg <= rbg_pkg::mulq(rbg_pkg::word_t'({1'b0, rbg_pkg::RST_GROUND_FRICTION}),
                                     rbg_pkg::RST_DELTA_TIME);
        end else begin
            gdt_reg <= rbg_pkg::mulq(rbg_pkg::word_t'({1'b0, grav_reg}), dt_reg);
            dec_reg <= rbg_pkg::mulq(rbg_pkg::word_t'({1'b0, fric_reg}), dt_reg);
        end
    end

    // most negative allowed vertical velocity
    assign term_neg = rbg_pkg::word_t'(-$signed({1'b0, term_reg}));

    // advance the pipeline when the output register is free or being drained
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    always_comb begin
        in_body.px           = rbg_pkg::word_t'(s_tdata[W-1:0]);
        in_body.py           = rbg_pkg::word_t'(s_tdata[2*W-1:W]);
        in_body.pz           = rbg_pkg::word_t'(s_tdata[3*W-1:2*W]);
        in_body.vx           = rbg_pkg::word_t'(s_tdata[4*W-1:3*W]);
        in_body.vy           = rbg_pkg::word_t'(s_tdata[5*W-1:4*W]);
        in_body.vz           = rbg_pkg::word_t'(s_tdata[6*W-1:5*W]);
        in_body.half_extent  = s_tdata[6*W+rbg_pkg::MAG_BITS-1:6*W];
        in_body.use_gravity  = s_tuser[0];
        in_body.has_collider = s_tuser[1];
    end

    // integrate and test against the ground plane
    rbg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_body   (in_body),
        .dt        (dt_reg),
        .gdt       (gdt_reg),
        .ground_y  (gy_reg),
        .term      (term_neg),
        .out_valid (fr_valid),
        .out_body  (fr_body),
        .out_rad   (fr_rad)
    );

    // horizontal speed of grounded bodies; zero for airborne ones
    rbg_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_body   (fr_body),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_body  (sq_body),
        .out_root  (sq_root)
    );

    // friction: rescale x and z velocity to the reduced speed
    rbg_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_body   (sq_body),
        .in_speed  (sq_root),
        .dec       (dec_reg),
        .out_valid (out_valid),
        .out_body  (out_body)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = {out_body.vz, out_body.vy, out_body.vx,
                         out_body.pz, out_body.py, out_body.px};
    assign m_tuser[0] = out_body.grounded;

    // a grounded body always leaves with zero vertical velocity
    a_grounded_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[5*W-1:4*W] == '0))
        else $error("grounded body with nonzero vertical velocity");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a grounded body sits no lower than the ground plane when the rest height is reachable
    a_grounded_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] && !gy_reg[W-1] && $stable(gy_reg))
            |-> ($signed(m_tdata[2*W-1:W]) >= gy_reg))
        else $error("grounded body below ground plane");

endmodule
`default_nettype wire
